// ===== rtl/rrbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rrbm_pkg
// Shared types and constants of the ROM/RAM bank mapper.
// ----------------------------------------------------------------------------
package rrbm_pkg;

  localparam int MAX_ROM_BANKS_DEFAULT = 128;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int PADDR_W    = 21;

  // result kinds
  localparam logic [2:0] KIND_ROM_READ  = 3'd0;
  localparam logic [2:0] KIND_RAM_READ  = 3'd1;
  localparam logic [2:0] KIND_OPEN_BUS  = 3'd2;
  localparam logic [2:0] KIND_RAM_WRITE = 3'd3;
  localparam logic [2:0] KIND_CONTROL   = 3'd4;
  localparam logic [2:0] KIND_FAULT     = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROM_BANK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RAM_BANK_COUNT = 1'b1;

  localparam logic [7:0] RAM_ENABLE_BYTE  = 8'h0A;
  localparam logic [7:0] RAM_DISABLE_BYTE = 8'h00;
  localparam logic [7:0] RAM_MODE_MAX     = 8'h03;
  localparam logic [7:0] CLOCK_MODE_MIN   = 8'h08;
  localparam logic [7:0] CLOCK_MODE_MAX   = 8'h0C;
  localparam logic [6:0] ROM_BANK_MASK    = 7'h7F;

  typedef struct packed {
    logic capture;
    logic start_div;
    logic step_div;
    logic load_out;
  } rrbm_cmd_t;

  typedef struct packed {
    logic banked;
    logic div_last;
  } rrbm_status_t;

endpackage

// ===== rtl/rrbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrbm_ctrl
// Sequencer: takes an access, steps the bank remainder unit when needed and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module rrbm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  rrbm_pkg::rrbm_status_t status,
  output rrbm_pkg::rrbm_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_FIN    = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign in_tready = (state == ST_IDLE);
  assign slot_free = !out_tvalid || out_tready;

  always_comb begin
    state_next    = state;
    cmd.capture   = 1'b0;
    cmd.start_div = 1'b0;
    cmd.step_div  = 1'b0;
    cmd.load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.banked) begin
          cmd.start_div = 1'b1;
          state_next    = ST_DIV;
        end else if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DIV: begin
        cmd.step_div = 1'b1;
        if (status.div_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
  end

endmodule

// ===== rtl/rrbm_dp.sv =====
// ----------------------------------------------------------------------------
// rrbm_dp
// Datapath: access register, bank state, address decode, two-bit-per-cycle
// ROM bank remainder unit and result register.
// ----------------------------------------------------------------------------
module rrbm_dp #(
  parameter int MaxRomBanks = rrbm_pkg::MAX_ROM_BANKS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [rrbm_pkg::IN_DATA_W-1:0]  in_data,
  input  logic                            cfg_we,
  input  logic [rrbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrbm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  rrbm_pkg::rrbm_cmd_t             cmd,
  output rrbm_pkg::rrbm_status_t          status,
  output logic [rrbm_pkg::OUT_DATA_W-1:0] out_data
);

  localparam logic [7:0] MAX_CNT = 8'(MaxRomBanks);

  // captured access
  logic        acc_write;
  logic [15:0] acc_addr;
  logic [7:0]  acc_byte;

  // configuration
  logic [7:0] rom_bank_count;
  logic [2:0] ram_bank_count;

  // bank state
  logic [6:0] rom_bank_select;
  logic [7:0] aux_bank_select;
  logic       ram_enabled;
  logic       clock_mode_selected;

  // remainder unit
  logic [7:0] rem;
  logic [7:0] dvd;
  logic [1:0] cnt;

  // result
  logic [2:0]                       res_kind;
  logic [rrbm_pkg::PADDR_W-1:0]     res_addr;
  logic [7:0]                       res_byte;

  logic [7:0] eff_rom;
  logic [2:0] eff_ram;
  logic [7:0] ram_sel;
  logic       in_ram;
  logic [2:0] dec_kind;
  logic [rrbm_pkg::PADDR_W-1:0] dec_addr;
  logic [7:0] dec_byte;
  logic       banked;
  logic [6:0] bank_nz;
  logic [8:0] t1;
  logic [8:0] t2;
  logic [7:0] r1;
  logic [7:0] r2;

  always_comb begin
    priority if (rom_bank_count < 8'd2) eff_rom = 8'd2;
    else if (rom_bank_count > MAX_CNT)   eff_rom = MAX_CNT;
    else                                 eff_rom = rom_bank_count;
    priority if (ram_bank_count == 3'd0) eff_ram = 3'd1;
    else if (ram_bank_count > 3'd4)      eff_ram = 3'd4;
    else                                 eff_ram = ram_bank_count;
  end

  assign in_ram   = (acc_addr[15:13] == 3'b101);
  assign ram_sel  = (acc_write && eff_ram == 3'd1) ? 8'd0 : aux_bank_select;
  assign banked   = !in_ram && !acc_addr[15] && !acc_write && acc_addr[14];
  assign bank_nz  = (rom_bank_select == 7'd0) ? 7'd1 : rom_bank_select;

  always_comb begin
    dec_kind = rrbm_pkg::KIND_CONTROL;
    dec_addr = '0;
    dec_byte = 8'd0;
    priority if (in_ram) begin
      priority if (!ram_enabled || clock_mode_selected) begin
        dec_kind = rrbm_pkg::KIND_OPEN_BUS;
      end else if (ram_sel >= {5'd0, eff_ram}) begin
        dec_kind = rrbm_pkg::KIND_FAULT;
      end else begin
        dec_addr = {6'd0, ram_sel[1:0], acc_addr[12:0]};
        if (acc_write) begin
          dec_kind = rrbm_pkg::KIND_RAM_WRITE;
          dec_byte = acc_byte;
        end else begin
          dec_kind = rrbm_pkg::KIND_RAM_READ;
        end
      end
    end else if (acc_addr[15]) begin
      dec_kind = rrbm_pkg::KIND_FAULT;
    end else if (!acc_write) begin
      dec_kind = rrbm_pkg::KIND_ROM_READ;
      dec_addr = {5'd0, acc_addr};
    end else begin
      dec_kind = rrbm_pkg::KIND_CONTROL;
    end
  end

  // two restoring steps of bank % eff_rom
  always_comb begin
    t1 = {rem, dvd[7]};
    r1 = (t1 >= {1'b0, eff_rom}) ? 8'(t1 - {1'b0, eff_rom}) : t1[7:0];
    t2 = {r1, dvd[6]};
    r2 = (t2 >= {1'b0, eff_rom}) ? 8'(t2 - {1'b0, eff_rom}) : t2[7:0];
  end

  assign status.banked   = banked;
  assign status.div_last = (cnt == 2'd3);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc_write <= in_data[0];
      acc_addr  <= in_data[16:1];
      acc_byte  <= in_data[24:17];
    end
    if (cmd.start_div) begin
      rem <= 8'd0;
      dvd <= {1'b0, bank_nz};
      cnt <= 2'd0;
    end else if (cmd.step_div) begin
      rem <= r2;
      dvd <= {dvd[5:0], 2'b00};
      cnt <= cnt + 2'd1;
    end
    if (cmd.load_out) begin
      if (banked) begin
        res_kind <= rrbm_pkg::KIND_ROM_READ;
        res_addr <= {rem[6:0], acc_addr[13:0]};
        res_byte <= 8'd0;
      end else begin
        res_kind <= dec_kind;
        res_addr <= dec_addr;
        res_byte <= dec_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_count      <= 8'd2;
      ram_bank_count      <= 3'd1;
      rom_bank_select     <= 7'd1;
      aux_bank_select     <= 8'd0;
      ram_enabled         <= 1'b0;
      clock_mode_selected <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rrbm_pkg::REG_ROM_BANK_COUNT: rom_bank_count <= cfg_data;
          rrbm_pkg::REG_RAM_BANK_COUNT: ram_bank_count <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (cmd.load_out && !banked && dec_kind == rrbm_pkg::KIND_CONTROL) begin
        unique case (acc_addr[14:13])
          2'b00: begin
            if (acc_byte == rrbm_pkg::RAM_ENABLE_BYTE) ram_enabled <= 1'b1;
            else if (acc_byte == rrbm_pkg::RAM_DISABLE_BYTE) ram_enabled <= 1'b0;
          end
          2'b01: rom_bank_select <= acc_byte[6:0] & rrbm_pkg::ROM_BANK_MASK;
          2'b10: begin
            if (acc_byte <= rrbm_pkg::RAM_MODE_MAX) clock_mode_selected <= 1'b0;
            else if (acc_byte >= rrbm_pkg::CLOCK_MODE_MIN &&
                     acc_byte <= rrbm_pkg::CLOCK_MODE_MAX) clock_mode_selected <= 1'b1;
            aux_bank_select <= acc_byte;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_data = {res_byte, res_addr, res_kind};

endmodule

// ===== rtl/rom_ram_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper
// Cartridge ROM/RAM bank controller: translates CPU bus accesses into ROM or
// RAM byte addresses and applies control-range writes.
//
//   channel   dir  beat contents
//   in        in   mode, bus_address, write_byte
//   out       out  access_kind, physical_address, store_byte
//   cfg       in   cfg_index selects rom_bank_count (0) or ram_bank_count (1)
//
// A switchable-bank ROM read passes decode, the bank remainder unit (two bits
// a cycle) and a finish state; every other access skips the remainder unit.
// One access is in flight at a time; a result waiting in the output
// register does not block the next accept. Reset is synchronous and restores
// the bank state and configuration at once.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper #(
  parameter int MaxRomBanks = rrbm_pkg::MAX_ROM_BANKS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] mode, [16:1] bus_address, [24:17] write_byte, [31:25] zero
  input  logic [rrbm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] access_kind, [23:3] physical_address, [31:24] store_byte
  output logic [rrbm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [rrbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrbm_pkg::CFG_DATA_W-1:0] cfg_data
);

  rrbm_pkg::rrbm_cmd_t    cmd;
  rrbm_pkg::rrbm_status_t status;

  rrbm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (s_axis_tvalid),
    .in_tready  (s_axis_tready),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .status     (status),
    .cmd        (cmd)
  );

  rrbm_dp #(
    .MaxRomBanks (MaxRomBanks)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_axis_tdata)
  );

endmodule
